// File: rtl/ltpd_pkg.sv
// Shared types and constants for the LT peeling decoder.
package ltpd_pkg;
  localparam int BLK_COUNT_DEF     = 64;
  localparam int BLOCK_BITS_DEF    = 64;
  localparam int PENDING_SLOTS_DEF = 128;

  typedef enum logic [1:0] {
    KIND_DECODED   = 2'd0,
    KIND_PENDING   = 2'd1,
    KIND_REDUNDANT = 2'd2,
    KIND_FULL      = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_STRIP, ST_CLASSIFY, ST_FINDSLOT, ST_WRITE, ST_FINAL,
    ST_QPOP, ST_QRD, ST_SRD, ST_SCHK, ST_SSTRIP, ST_SDONE
  } state_t;
endpackage

// File: rtl/ltpd_strip.sv
// Shared strip unit: XORs one known block per cycle out of a mask/data pair.
module ltpd_strip import ltpd_pkg::*; #(
  parameter int BLK_COUNT  = BLK_COUNT_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [BLK_COUNT-1:0]  mask_in,
  input  logic [BLOCK_BITS-1:0] data_in,
  input  logic [BLK_COUNT-1:0]  known,
  input  logic [BLOCK_BITS-1:0] store_rdata,
  output logic [$clog2(BLK_COUNT)-1:0] store_raddr,
  output logic                  done,
  output logic [BLK_COUNT-1:0]  mask_out,
  output logic [BLOCK_BITS-1:0] data_out
);
  localparam int IW = $clog2(BLK_COUNT);
  logic [BLK_COUNT-1:0]  work;
  logic [BLOCK_BITS-1:0] acc;
  logic                  busy, rd_pend;
  logic [BLK_COUNT-1:0]  low_bit;

  assign low_bit = work & (~work + BLK_COUNT'(1));

  always_comb begin
    store_raddr = '0;
    for (int i = 0; i < BLK_COUNT; i++)
      if (low_bit[i]) store_raddr = IW'(i);
  end

  // store read is registered, so data arrives in the cycle after the address
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; rd_pend <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; rd_pend <= 1'b0;
        work <= mask_in & known;
        acc <= data_in;
        mask_out <= mask_in & ~known;
      end else if (busy) begin
        if (rd_pend) acc <= acc ^ store_rdata;
        if (work != '0) begin
          work <= work & ~low_bit;
          rd_pend <= 1'b1;
        end else begin
          rd_pend <= 1'b0;
          if (!rd_pend) begin
            busy <= 1'b0; done <= 1'b1;
          end
        end
      end
    end
  end
  assign data_out = acc;
endmodule

// File: rtl/lt_peeling_decoder_top.sv
// LT peeling decoder: one chunk in, a run of decoded-block or status beats out.
// A chunk first has its known blocks stripped and is then classified; a status beat is then
// registered, after a scan for a free slot if the chunk is held. Each decoded block is
// queued, and every slot is read and checked; a pending slot holding it is stripped too.
// One chunk at a time: not ready until its last beat is registered.
// Sync active-high rst clears known set, pending valid bits, count, msg_total (to 64).
module lt_peeling_decoder_top import ltpd_pkg::*; #(
  parameter int BLK_COUNT     = BLK_COUNT_DEF,
  parameter int BLOCK_BITS    = BLOCK_BITS_DEF,
  parameter int PENDING_SLOTS = PENDING_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // chunk_blocks[63:0], chunk_data[127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,  // block_index[5:0], block_data[69:6],
                                      // decoded_count[76:70], zero pad
  output logic [2:0]   m_axis_tuser,  // result_kind[1:0], all_decoded[2]
  output logic         m_axis_tlast
);
  localparam int IW = $clog2(BLK_COUNT);
  localparam int SW = $clog2(PENDING_SLOTS);
  localparam int CW = $clog2(BLK_COUNT + 1);
  localparam logic [SW:0] SLOT_END  = (SW+1)'(PENDING_SLOTS);
  localparam logic [SW:0] SLOT_LAST = (SW+1)'(PENDING_SLOTS - 1);

  state_t state, state_next;
  logic [6:0] msg_total;
  logic [BLK_COUNT-1:0] known;
  logic [CW-1:0] dec_total, cnt_inc;
  logic all_now, all_inc;
  logic [PENDING_SLOTS-1:0] pvalid;
  logic [BLK_COUNT-1:0] pmask_mem [PENDING_SLOTS];
  logic [BLOCK_BITS-1:0] pdata_mem [PENDING_SLOTS];
  logic [BLOCK_BITS-1:0] store_mem [BLK_COUNT];
  logic [IW-1:0] queue_mem [BLK_COUNT];
  logic [IW:0] q_head, q_tail;
  logic [IW-1:0] cur_blk, q_rdata;
  logic [SW:0] slot;
  logic last_slot;
  logic [BLK_COUNT-1:0] pm_rd;
  logic [BLOCK_BITS-1:0] pd_rd, st_rd;
  logic [BLK_COUNT-1:0] cur_mask;
  logic [BLOCK_BITS-1:0] cur_data;

  logic st_start, st_done;
  logic [BLK_COUNT-1:0] st_min, st_mout;
  logic [BLOCK_BITS-1:0] st_din, st_dout;
  logic [IW-1:0] st_raddr;

  logic out_full, out_last;
  kind_t out_kind;
  logic [IW-1:0] out_idx;
  logic [BLOCK_BITS-1:0] out_data;
  logic [CW-1:0] out_cnt;
  logic out_all;

  // result held back until it is known whether another one follows
  kind_t h_kind;
  logic [IW-1:0] h_idx;
  logic [BLOCK_BITS-1:0] h_data;
  logic [CW-1:0] h_cnt;
  logic h_all;

  logic [BLK_COUNT-1:0] rm_low;
  logic rm_one;
  logic [IW-1:0] rm_idx;
  logic do_dec;

  assign cfg_ready = (state == ST_IDLE);
  assign s_axis_tready = (state == ST_IDLE);

  ltpd_strip #(.BLK_COUNT(BLK_COUNT), .BLOCK_BITS(BLOCK_BITS)) u_strip (
    .clk, .rst, .start(st_start), .mask_in(st_min), .data_in(st_din),
    .known, .store_rdata(st_rd), .store_raddr(st_raddr), .done(st_done),
    .mask_out(st_mout), .data_out(st_dout)
  );

  assign rm_low = st_mout & (~st_mout + BLK_COUNT'(1));
  assign rm_one = (st_mout != '0) && (rm_low == st_mout);
  always_comb begin
    rm_idx = '0;
    for (int i = 0; i < BLK_COUNT; i++)
      if (rm_low[i]) rm_idx = IW'(i);
  end

  assign cnt_inc   = dec_total + CW'(1);
  assign all_now   = 8'(dec_total) >= 8'(msg_total);
  assign all_inc   = 8'(cnt_inc) >= 8'(msg_total);
  assign last_slot = (slot == SLOT_LAST);
  // a decode in the cascade first pushes the previous result out
  assign do_dec = rm_one && ((state == ST_CLASSIFY && st_done) ||
                             (state == ST_SDONE && !out_full));

  always_ff @(posedge clk) begin
    st_rd <= store_mem[st_raddr];
    q_rdata <= queue_mem[q_head[IW-1:0]];
    pm_rd <= pmask_mem[slot[SW-1:0]];
    pd_rd <= pdata_mem[slot[SW-1:0]];
    if (!rst) begin
      if (do_dec) begin
        store_mem[rm_idx] <= st_dout;
        queue_mem[q_tail[IW-1:0]] <= rm_idx;
      end
      if (state == ST_WRITE && slot != SLOT_END) begin
        pmask_mem[slot[SW-1:0]] <= cur_mask;
        pdata_mem[slot[SW-1:0]] <= cur_data;
      end else if (state == ST_SDONE && st_mout != '0 && !rm_one) begin
        pmask_mem[slot[SW-1:0]] <= st_mout;
        pdata_mem[slot[SW-1:0]] <= st_dout;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (s_axis_tvalid && s_axis_tready) state_next = ST_STRIP;
      ST_STRIP:    state_next = ST_CLASSIFY;
      ST_CLASSIFY: if (st_done) begin
        if (st_mout == '0) state_next = ST_FINAL;
        else if (rm_one) state_next = ST_QPOP;
        else state_next = ST_FINDSLOT;
      end
      ST_FINDSLOT: if (slot == SLOT_END || !pvalid[slot[SW-1:0]])
                     state_next = ST_WRITE;
      ST_WRITE:    state_next = ST_FINAL;
      ST_FINAL:    if (!out_full) state_next = ST_IDLE;
      ST_QPOP:     state_next = (q_head == q_tail) ? ST_FINAL : ST_QRD;
      ST_QRD:      state_next = ST_SRD;
      ST_SRD:      state_next = ST_SCHK;
      ST_SCHK: begin
        if (st_start) state_next = ST_SSTRIP;
        else state_next = last_slot ? ST_QPOP : ST_SRD;
      end
      ST_SSTRIP:   if (st_done) state_next = ST_SDONE;
      ST_SDONE:    if (!(rm_one && out_full)) state_next = last_slot ? ST_QPOP : ST_SRD;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    st_start = 1'b0;
    st_min = cur_mask;
    st_din = cur_data;
    if (state == ST_STRIP) st_start = 1'b1;
    if (state == ST_SCHK) begin
      st_min = pm_rd; st_din = pd_rd;
      st_start = pvalid[slot[SW-1:0]] && pm_rd[cur_blk];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      msg_total <= 7'd64;
      known <= '0;
      dec_total <= '0;
      pvalid <= '0;
      out_full <= 1'b0;
      out_last <= 1'b0;
      out_kind <= KIND_DECODED;
      out_idx <= '0; out_data <= '0; out_cnt <= '0; out_all <= 1'b0;
      q_head <= '0; q_tail <= '0; slot <= '0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready) out_full <= 1'b0;
      if (cfg_valid && cfg_ready) msg_total <= cfg_data;
      case (state)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          cur_mask <= s_axis_tdata[BLK_COUNT-1:0];
          cur_data <= s_axis_tdata[64 +: BLOCK_BITS];
          q_head <= '0; q_tail <= '0; slot <= '0;
        end
        ST_CLASSIFY: if (st_done) begin
          cur_mask <= st_mout; cur_data <= st_dout;
          if (st_mout == '0) begin
            h_kind <= KIND_REDUNDANT; h_idx <= '0; h_data <= '0;
            h_cnt <= dec_total; h_all <= all_now;
          end
        end
        ST_FINDSLOT:
          if (slot != SLOT_END && pvalid[slot[SW-1:0]]) slot <= slot + 1'b1;
        ST_WRITE: begin
          h_idx <= '0; h_data <= '0; h_cnt <= dec_total; h_all <= all_now;
          if (slot == SLOT_END) h_kind <= KIND_FULL;
          else begin
            h_kind <= KIND_PENDING;
            pvalid[slot[SW-1:0]] <= 1'b1;
          end
        end
        ST_FINAL: if (!out_full) begin
          out_full <= 1'b1; out_last <= 1'b1;
          out_kind <= h_kind; out_idx <= h_idx; out_data <= h_data;
          out_cnt <= h_cnt; out_all <= h_all;
        end
        ST_QRD: begin
          cur_blk <= q_rdata;
          q_head <= q_head + 1'b1;
          slot <= '0;
        end
        ST_SCHK: if (!st_start && !last_slot) slot <= slot + 1'b1;
        ST_SDONE: if (!(rm_one && out_full)) begin
          if (!last_slot) slot <= slot + 1'b1;
          if (st_mout == '0 || rm_one) pvalid[slot[SW-1:0]] <= 1'b0;
          if (rm_one) begin
            out_full <= 1'b1; out_last <= 1'b0;
            out_kind <= h_kind; out_idx <= h_idx; out_data <= h_data;
            out_cnt <= h_cnt; out_all <= h_all;
          end
        end
        default: ;
      endcase
      if (do_dec) begin
        known[rm_idx] <= 1'b1;
        q_tail <= q_tail + 1'b1;
        dec_total <= cnt_inc;
        h_kind <= KIND_DECODED; h_idx <= rm_idx; h_data <= st_dout;
        h_cnt <= cnt_inc; h_all <= all_inc;
      end
    end
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {3'b0, 7'(out_cnt), 64'(out_data), 6'(out_idx)};
  assign m_axis_tuser  = {out_all, out_kind};
  assign m_axis_tlast  = out_last;
endmodule

// File: test/lt_peeling_decoder_checker.sv
// Bus monitor, chunk decode predictor and result comparator for the LT peeling decoder.
`timescale 1ns / 100ps
module lt_peeling_decoder_checker import ltpd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [6:0]   cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // chunk_blocks[63:0], chunk_data[127:64]
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [79:0]  m_axis_tdata,  // block_index[5:0], block_data[69:6], decoded_count[76:70]
  input  logic [2:0]   m_axis_tuser,  // result_kind[1:0], all_decoded[2]
  input  logic         m_axis_tlast,
  output int           fail_count,
  output int           results_owed
);
  localparam int SLOTS = PENDING_SLOTS_DEF;

  typedef struct {
    kind_t       kind;
    logic [5:0]  idx;
    logic [63:0] data;
    logic [6:0]  count;
    logic        all_done;
    logic        last;
  } beat_t;

  beat_t       owed_beats[$];
  logic [6:0]  msg_blocks;
  logic [63:0] known;
  logic [63:0] recovered [64];
  logic        slot_used [SLOTS];
  logic [63:0] slot_mask [SLOTS];
  logic [63:0] slot_data [SLOTS];
  logic [6:0]  n_decoded;
  int          peel_fifo[$];

  assign results_owed = owed_beats.size();

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic int lowest_bit(input logic [63:0] v);
    for (int i = 0; i < 64; i++) if (v[i]) return i;
    return 63;
  endfunction

  task automatic peel_known(inout logic [63:0] mask, inout logic [63:0] data);
    for (int b = 0; b < 64; b++) if (mask[b] && known[b]) data ^= recovered[b];
    mask &= ~known;
  endtask

  task automatic push_beat(input kind_t k, input int idx, input logic [63:0] data);
    beat_t r;
    r.kind = k;
    r.idx = idx[5:0];
    r.data = data;
    r.count = n_decoded;
    r.all_done = (n_decoded >= msg_blocks);
    r.last = 1'b0;
    owed_beats = {owed_beats, r};
  endtask

  task automatic recover_block(input int b, input logic [63:0] data);
    known[b] = 1'b1;
    recovered[b] = data;
    n_decoded++;
    peel_fifo = {peel_fifo, b};
    push_beat(KIND_DECODED, b, data);
  endtask

  task automatic predict_chunk(input logic [63:0] mask_in, input logic [63:0] data_in);
    logic [63:0] mask, data;
    int b, s;
    mask = mask_in;
    data = data_in;
    peel_known(mask, data);
    peel_fifo.delete();
    if (mask == 0) begin
      push_beat(KIND_REDUNDANT, 0, 64'd0);
    end else if ($countones(mask) == 1) begin
      recover_block(lowest_bit(mask), data);
      // breadth-first ripple through the held chunks
      while (peel_fifo.size() > 0) begin
        b = peel_fifo.pop_front();
        for (int j = 0; j < SLOTS; j++) begin
          if (!slot_used[j] || !slot_mask[j][b]) continue;
          peel_known(slot_mask[j], slot_data[j]);
          if (slot_mask[j] == 0) begin
            slot_used[j] = 1'b0;
          end else if ($countones(slot_mask[j]) == 1) begin
            slot_used[j] = 1'b0;
            recover_block(lowest_bit(slot_mask[j]), slot_data[j]);
          end
        end
      end
    end else begin
      s = 0;
      while (s < SLOTS && slot_used[s]) s++;
      if (s < SLOTS) begin
        slot_used[s] = 1'b1;
        slot_mask[s] = mask;
        slot_data[s] = data;
        push_beat(KIND_PENDING, 0, 64'd0);
      end else begin
        push_beat(KIND_FULL, 0, 64'd0);
      end
    end
    owed_beats[$].last = 1'b1;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    beat_t e;
    if (rst) begin
      msg_blocks = 7'd64;
      known = '0;
      n_decoded = '0;
      for (int j = 0; j < SLOTS; j++) slot_used[j] = 1'b0;
      owed_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) msg_blocks = cfg_data;
      if (s_axis_tvalid && s_axis_tready) predict_chunk(s_axis_tdata[63:0], s_axis_tdata[127:64]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_beats.size() == 0) begin
          report($sformatf("unexpected result beat tdata=%h", m_axis_tdata));
        end else begin
          e = owed_beats.pop_front();
          if (m_axis_tuser[1:0] != e.kind)
            report($sformatf("kind %0d, want %0d", m_axis_tuser[1:0], e.kind));
          if (m_axis_tdata[5:0] != e.idx)
            report($sformatf("block_index %0d, want %0d", m_axis_tdata[5:0], e.idx));
          if (m_axis_tdata[69:6] != e.data)
            report($sformatf("block_data %h, want %h", m_axis_tdata[69:6], e.data));
          if (m_axis_tdata[76:70] != e.count)
            report($sformatf("decoded_count %0d, want %0d", m_axis_tdata[76:70], e.count));
          if (m_axis_tdata[79:77] != 3'd0) report("nonzero pad bits");
          if (m_axis_tuser[2] != e.all_done)
            report($sformatf("all_decoded %0b, want %0b", m_axis_tuser[2], e.all_done));
          if (m_axis_tlast != e.last)
            report($sformatf("tlast %0b, want %0b", m_axis_tlast, e.last));
        end
      end
    end
  end
endmodule

// File: test/lt_peeling_decoder_top_test.sv
// Stimulus, clock, reset and verdict for the LT peeling decoder testbench.
`timescale 1ns / 100ps
module lt_peeling_decoder_top_test;
  import ltpd_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [6:0]   cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // chunk_blocks[63:0], chunk_data[127:64]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [79:0]  m_axis_tdata;       // block_index[5:0], block_data[69:6], decoded_count[76:70]
  logic [2:0]   m_axis_tuser;       // result_kind[1:0], all_decoded[2]
  logic         m_axis_tlast;
  int           fail_count;
  int           results_owed;

  logic [63:0]  source [64];
  int           burst_left = 0;
  bit           no_gaps = 0;
  int           ready_mode = 0;
  int           mode_cycles = 0;

  lt_peeling_decoder_top dut (.*);

  lt_peeling_decoder_checker chk (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: always ready, coin flip, or long stalls, switching every so often
  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_cycles = $urandom_range(16, 128);
    end
    mode_cycles--;
    case (ready_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  task automatic send_chunk(input logic [63:0] mask, input logic [63:0] data);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {data, mask};
    do @(posedge clk); while (!s_axis_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      if (!no_gaps) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
  endtask

  function automatic logic [63:0] encode(input logic [63:0] mask);
    logic [63:0] d = '0;
    for (int i = 0; i < 64; i++) if (mask[i]) d ^= source[i];
    return d;
  endfunction

  task automatic send_blocks(input logic [63:0] mask);
    send_chunk(mask, encode(mask));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_total(input logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly consistent chunks of low degree over blocks lo..hi, some raw noise
  task automatic random_chunks(input int n, input int lo, input int hi);
    logic [63:0] mask;
    int deg;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_chunk({$urandom, $urandom}, {$urandom, $urandom});
      end else begin
        mask = '0;
        deg = ($urandom_range(0, 9) < 4) ? 1 : $urandom_range(2, 4);
        for (int j = 0; j < deg; j++) mask[$urandom_range(lo, hi)] = 1'b1;
        send_blocks(mask);
      end
      if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
    end
  endtask

  initial begin
    for (int i = 0; i < 64; i++) source[i] = {$urandom, $urandom};
    source[0] = '1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_total(7'd16);
    send_chunk('0, {$urandom, $urandom});   // empty chunk
    send_blocks(64'h0000_0000_0000_0001);   // block 0, all-ones payload
    send_blocks(64'h0000_0000_0000_0001);   // already known
    send_blocks(64'h0000_0000_0000_0003);   // known block stripped, 1 decoded
    send_blocks(64'h0000_0000_0000_000C);   // chain: {2,3} {3,4} held
    send_blocks(64'h0000_0000_0000_0018);
    send_blocks(64'h0000_0000_0000_0004);   // 2 ripples to 3 and 4
    send_blocks(64'h0000_0000_0000_0060);   // twin chunks {5,6}
    send_blocks(64'h0000_0000_0000_0060);
    send_blocks(64'h0000_0000_0000_0020);   // second twin freed without a result
    send_chunk('1, '1);                     // every block, held
    send_chunk('1, '0);
    send_chunk(64'h8000_0000_0000_0001, {$urandom, $urandom});
    wait_idle();   // hold off until every result is back
    random_chunks(30, 0, 15);
    wait_idle();

    write_total(7'd1);
    random_chunks(8, 0, 20);
    wait_idle();

    write_total(7'd40);
    random_chunks(25, 16, 39);
    wait_idle();

    write_total(7'd64);
    random_chunks(15, 40, 55);
    // back-to-back pairs over untouched blocks, then singles that ripple through them
    no_gaps = 1;
    for (int k = 0; k < 10; k++) begin
      logic [63:0] mask;
      mask = '0;
      mask[$urandom_range(56, 59)] = 1'b1;
      mask[$urandom_range(60, 63)] = 1'b1;
      send_blocks(mask);
    end
    no_gaps = 0;
    for (int b = 56; b < 64; b++) send_blocks(64'd1 << b);
    random_chunks(6, 0, 63);
    wait_idle();
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/ltpd_pkg.sv
rtl/ltpd_strip.sv
rtl/lt_peeling_decoder_top.sv
test/lt_peeling_decoder_checker.sv
test/lt_peeling_decoder_top_test.sv
